>>> sv/exclusive_lease_table_top_assert.svh
// Assertion macros for the lease table checker.
`ifndef EXCLUSIVE_LEASE_TABLE_TOP_ASSERT_SVH
`define EXCLUSIVE_LEASE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define ELT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ELT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/elt_pkg.sv
package elt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int HANDLE_W          = 4;
  localparam logic [15:0] LIFETIME_RESET = 16'd300;  // 5 * 60

  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RENEW   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_HELD     = 3'd1,
    ST_BROKEN   = 3'd2,
    ST_FULL     = 3'd3,
    ST_RELEASED = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]          command;
    logic [7:0]          fs_id;
    logic [63:0]         key_path;
    logic [HANDLE_W-1:0] lease_handle;
    logic [31:0]         now_time;
  } elt_in_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [HANDLE_W-1:0] granted_handle;
  } elt_out_t;

  // One stored lease.
  typedef struct packed {
    logic [7:0]  owner_fs;
    logic [63:0] locked_path;
    logic [31:0] expiry_time;
  } elt_entry_t;

  // Compare unit flags.
  typedef struct packed {
    logic key_eq;
    logic owner_eq;
    logic unexpired;
  } elt_cmp_t;

endpackage

>>> sv/elt_mem.sv
module elt_mem #(
  parameter int DEPTH = elt_pkg::TABLE_ENTRIES_DEF,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IW-1:0]       waddr_i,
  input  elt_pkg::elt_entry_t wdata_i,
  input  logic                re_i,
  input  logic [IW-1:0]       raddr_i,
  output elt_pkg::elt_entry_t rdata_o
);
  import elt_pkg::*;

  elt_entry_t mem_q [DEPTH];
  elt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/elt_match.sv
// Shared compare unit: key match, expiry check and new expiry.
module elt_match (
  input  elt_pkg::elt_entry_t entry_i,
  input  logic [7:0]          fs_id_i,
  input  logic [63:0]         key_path_i,
  input  logic [31:0]         now_time_i,
  input  logic [15:0]         lifetime_i,
  output elt_pkg::elt_cmp_t   cmp_o,
  output logic [31:0]         new_expiry_o
);
  import elt_pkg::*;

  always_comb begin
    cmp_o.owner_eq  = (entry_i.owner_fs == fs_id_i);
    cmp_o.key_eq    = cmp_o.owner_eq && (entry_i.locked_path == key_path_i);
    cmp_o.unexpired = (entry_i.expiry_time >= now_time_i);
  end

  // wraps in 32 bits
  assign new_expiry_o = now_time_i + {16'd0, lifetime_i};

endmodule

>>> sv/exclusive_lease_table_top.sv
// Channel   Handshake            Payload
// ------    -------------------  -----------------------------------------
// request   start_i / busy_o     req_i (elt_in_t): command, fs_id, key_path,
//                                lease_handle, now_time
// result    done_o (strobe)      rsp_o (elt_out_t): status, granted_handle
// config    cfg_we_i             cfg_wdata_i: lease_lifetime (16 bits)
//
// Acquire reads every slot once through the registered-read lease memory, then
// allocates in S_ALLOC, or ends sooner if a live lease refuses. Renew reads its
// slot in S_RN_RD and checks it in S_RN_CK; release and unknown command answer
// straight from S_IDLE.
// done_o pulses one cycle, the receiver cannot stall it; a new item may start then.
// Reset clears used/live bits, lifetime to 300; data of free slots is never used.
module exclusive_lease_table_top #(
  parameter int TABLE_ENTRIES = elt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  elt_pkg::elt_in_t req_i,
  output logic             done_o,
  output elt_pkg::elt_out_t rsp_o,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i
);
  import elt_pkg::*;

  localparam int IW    = $clog2(TABLE_ENTRIES);
  // 4-bit handles reach only the first 16 slots
  localparam int LIMIT = (TABLE_ENTRIES < 16) ? TABLE_ENTRIES : 16;
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_ALLOC = 5'b00100,
    S_RN_RD = 5'b01000,
    S_RN_CK = 5'b10000
  } state_e;

  state_e state_q, state_d;
  elt_in_t req_q, req_d;
  elt_out_t rsp_q, rsp_d;
  logic done_q, done_d;
  logic [15:0] life_q, life_d;
  logic [TABLE_ENTRIES-1:0] used_q, used_d, live_q, live_d;

  // scan pipeline: read stage and compare stage
  logic rd_act_q, rd_act_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic cmp_v_q, cmp_v_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  // lowest free slot seen so far
  logic free_v_q, free_v_d;
  logic [IW-1:0] free_idx_q, free_idx_d;

  logic mem_re, mem_we;
  logic [IW-1:0] mem_raddr, mem_waddr;
  elt_entry_t mem_wdata, mem_rdata;
  elt_cmp_t cmp;
  logic [31:0] new_exp;

  logic [IW-1:0] h_idx, in_h_idx;
  logic h_ok, in_h_ok, refuse;

  elt_mem #(
    .DEPTH(TABLE_ENTRIES),
    .IW   (IW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  elt_match u_match (
    .entry_i     (mem_rdata),
    .fs_id_i     (req_q.fs_id),
    .key_path_i  (req_q.key_path),
    .now_time_i  (req_q.now_time),
    .lifetime_i  (life_q),
    .cmp_o       (cmp),
    .new_expiry_o(new_exp)
  );

  assign h_idx    = IW'(req_q.lease_handle);
  assign h_ok     = int'(req_q.lease_handle) < TABLE_ENTRIES;
  assign in_h_idx = IW'(req_i.lease_handle);
  assign in_h_ok  = int'(req_i.lease_handle) < TABLE_ENTRIES;

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    rsp_d      = rsp_q;
    done_d     = 1'b0;
    life_d     = cfg_we_i ? cfg_wdata_i : life_q;
    used_d     = used_q;
    live_d     = live_q;
    rd_act_d   = rd_act_q;
    rd_idx_d   = rd_idx_q;
    cmp_v_d    = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    free_v_d   = free_v_q;
    free_idx_d = free_idx_q;
    refuse     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = rd_idx_q;
    mem_we     = 1'b0;
    mem_waddr  = free_idx_q;
    mem_wdata  = '{owner_fs: req_q.fs_id, locked_path: req_q.key_path,
                   expiry_time: new_exp};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          case (req_i.command)
            CMD_ACQUIRE: begin
              state_d  = S_SCAN;
              rd_act_d = 1'b1;
              rd_idx_d = '0;
              free_v_d = 1'b0;
            end
            CMD_RENEW: begin
              state_d = S_RN_RD;
            end
            CMD_RELEASE: begin
              if (in_h_ok) begin
                used_d[in_h_idx] = 1'b0;
                live_d[in_h_idx] = 1'b0;
              end
              done_d = 1'b1;
              rsp_d  = '{status: ST_RELEASED, granted_handle: '0};
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = '{status: ST_HELD, granted_handle: '0};
            end
          endcase
        end
      end

      S_SCAN: begin
        mem_re    = rd_act_q;
        mem_raddr = rd_idx_q;
        if (rd_act_q) begin
          if (rd_idx_q == LAST) begin
            rd_act_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + IW'(1);
          end
        end
        cmp_v_d   = rd_act_q;
        cmp_idx_d = rd_idx_q;

        if (cmp_v_q) begin
          if (used_q[cmp_idx_q] && live_q[cmp_idx_q] && cmp.key_eq) begin
            if (cmp.unexpired) begin
              refuse = 1'b1;
            end else begin
              live_d[cmp_idx_q] = 1'b0;  // stale lease loses its key
            end
          end
          if (!used_q[cmp_idx_q] && !free_v_q && (int'(cmp_idx_q) < LIMIT)) begin
            free_v_d   = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (refuse) begin
            state_d  = S_IDLE;
            rd_act_d = 1'b0;
            cmp_v_d  = 1'b0;
            done_d   = 1'b1;
            rsp_d    = '{status: ST_HELD, granted_handle: '0};
          end else if (cmp_idx_q == LAST) begin
            state_d = S_ALLOC;
          end
        end
      end

      S_ALLOC: begin
        if (free_v_q) begin
          mem_we             = 1'b1;
          mem_waddr          = free_idx_q;
          used_d[free_idx_q] = 1'b1;
          live_d[free_idx_q] = 1'b1;
          rsp_d = '{status: ST_GRANTED, granted_handle: HANDLE_W'(free_idx_q)};
        end else begin
          rsp_d = '{status: ST_FULL, granted_handle: '0};
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_RN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = h_idx;
        state_d   = S_RN_CK;
      end

      S_RN_CK: begin
        if (h_ok && used_q[h_idx] && live_q[h_idx] && cmp.unexpired && cmp.owner_eq) begin
          mem_we    = 1'b1;
          mem_waddr = h_idx;
          mem_wdata = '{owner_fs: mem_rdata.owner_fs,
                        locked_path: mem_rdata.locked_path,
                        expiry_time: new_exp};
          rsp_d     = '{status: ST_GRANTED, granted_handle: '0};
        end else begin
          rsp_d     = '{status: ST_BROKEN, granted_handle: '0};
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      life_q   <= LIFETIME_RESET;
      used_q   <= '0;
      live_q   <= '0;
      rd_act_q <= 1'b0;
      cmp_v_q  <= 1'b0;
      free_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      life_q   <= life_d;
      used_q   <= used_d;
      live_q   <= live_d;
      rd_act_q <= rd_act_d;
      cmp_v_q  <= cmp_v_d;
      free_v_q <= free_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    rsp_q      <= rsp_d;
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> sv/elt_chk.sv
`include "exclusive_lease_table_top_assert.svh"

module elt_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input elt_pkg::elt_out_t rsp_o
);
  import elt_pkg::*;

  // an accepted item either occupies the block or answers at once
  `ELT_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start_i && !busy_o, busy_o || done_o, "accepted item neither busy nor answered")

  // a result ends the item
  `ELT_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy_o, "result shown while still busy")

  // status codes stay within the defined set
  `ELT_ASSERT_NOW(a_status_code, clk_i, rst_ni, done_o, rsp_o.status <= ST_RELEASED, "undefined status code")

  // a handle comes back only with a grant
  `ELT_ASSERT_NOW(a_handle_zero, clk_i, rst_ni, done_o && (rsp_o.status != ST_GRANTED), rsp_o.granted_handle == '0, "handle set on a non-grant result")

endmodule

bind exclusive_lease_table_top elt_chk u_elt_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

>>> sim/exclusive_lease_table_top_test.sv
module exclusive_lease_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import elt_pkg::*;

  // Table geometry as built; handles only reach the first 16 slots.
  localparam int ENTRIES     = TABLE_ENTRIES_DEF;
  localparam int REACH       = (ENTRIES < 16) ? ENTRIES : 16;
  // Command code with no meaning in the block.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Quiet cycles allowed before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Settle time after the last result, longer than one full acquire scan.
  localparam int DRAIN_TAIL  = ENTRIES + 4;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  elt_in_t     req_i;
  logic        done_o;
  elt_out_t    rsp_o;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  exclusive_lease_table_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------
  // Lease table shadow: mirrors the block's slots and lifetime register.
  // ---------------------------------------------------------------------
  logic [15:0] lease_len;
  logic        slot_busy   [ENTRIES];
  logic        slot_keyed  [ENTRIES];
  logic [7:0]  slot_owner  [ENTRIES];
  logic [63:0] slot_path   [ENTRIES];
  logic [31:0] slot_expiry [ENTRIES];

  // Outcomes owed by the block, oldest first.
  elt_out_t pending_outcomes[$];
  elt_out_t outcome_want;
  int       mismatch_count;

  // Stimulus state.
  logic        steady_sender;  // no random gaps when set
  logic [31:0] now_clock;      // running time for random items
  logic [7:0]  fs_pool   [4];
  logic [63:0] path_pool [6];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one item to the shadow table and return the outcome it earns.
  function automatic elt_out_t lease_outcome(input elt_in_t item);
    elt_out_t    res;
    logic [31:0] new_expiry;
    res        = '0;
    new_expiry = item.now_time + {16'd0, lease_len};
    case (item.command)
      CMD_ACQUIRE: begin
        // Scan for a keyed match: still live refuses, expired gets unkeyed.
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_busy[i] && slot_keyed[i] && slot_owner[i] == item.fs_id &&
              slot_path[i] == item.key_path) begin
            if (slot_expiry[i] >= item.now_time) begin
              res.status = ST_HELD;
              return res;
            end
            slot_keyed[i] = 1'b0;
          end
        end
        for (int i = 0; i < REACH; i++) begin
          if (!slot_busy[i]) begin
            slot_busy[i]   = 1'b1;
            slot_keyed[i]  = 1'b1;
            slot_owner[i]  = item.fs_id;
            slot_path[i]   = item.key_path;
            slot_expiry[i] = new_expiry;
            res.status         = ST_GRANTED;
            res.granted_handle = HANDLE_W'(i);
            return res;
          end
        end
        res.status = ST_FULL;
      end
      CMD_RENEW: begin
        if (int'(item.lease_handle) >= ENTRIES || !slot_busy[item.lease_handle] ||
            !slot_keyed[item.lease_handle] ||
            slot_expiry[item.lease_handle] < item.now_time ||
            slot_owner[item.lease_handle] != item.fs_id) begin
          res.status = ST_BROKEN;
        end else begin
          slot_expiry[item.lease_handle] = new_expiry;
          res.status = ST_GRANTED;
        end
      end
      CMD_RELEASE: begin
        if (int'(item.lease_handle) < ENTRIES) begin
          slot_busy[item.lease_handle]  = 1'b0;
          slot_keyed[item.lease_handle] = 1'b0;
        end
        res.status = ST_RELEASED;
      end
      default: res.status = ST_HELD;  // unknown command is refused, no change
    endcase
    return res;
  endfunction

  function automatic elt_in_t make_req(input logic [1:0] cmd, input logic [7:0] fs,
                                       input logic [63:0] path, input logic [3:0] handle,
                                       input logic [31:0] now);
    elt_in_t item;
    item.command      = cmd;
    item.fs_id        = fs;
    item.key_path     = path;
    item.lease_handle = handle;
    item.now_time     = now;
    return item;
  endfunction

  // ---------------------------------------------------------------------
  // Driving. Inputs change on the falling edge; start_i is left high after
  // an accept so back-to-back items keep it up without a dip.
  // ---------------------------------------------------------------------
  task automatic send_item(input elt_in_t item);
    int gap;
    gap = 0;
    if (!steady_sender && $urandom_range(99) < 12) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= item;
    do @(posedge clk_i); while (busy_o);
    // Accepted at this edge: the shadow table moves on now.
    pending_outcomes.push_back(lease_outcome(item));
  endtask

  // Stop sending and wait until every owed outcome has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_outcomes.size() > 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  // Lifetime writes only happen with the block idle.
  task automatic set_lifetime(input logic [15:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 16'($urandom);
    lease_len = value;
  endtask

  task automatic refresh_pools();
    foreach (fs_pool[i]) fs_pool[i] = 8'($urandom);
    foreach (path_pool[i]) path_pool[i] = {$urandom, $urandom};
  endtask

  // Mostly well-formed traffic: acquires on a small key pool so matches
  // happen, renews and releases aimed at occupied slots, plus some noise.
  task automatic rand_request(output elt_in_t item);
    int pick;
    int clock_pick;
    int step_max;
    int slot;
    int live_slots[$];
    pick       = $urandom_range(99);
    clock_pick = $urandom_range(99);
    step_max   = int'(lease_len) / 2 + 2;
    if (clock_pick < 4) begin
      now_clock = $urandom;
    end else if (clock_pick < 6) begin
      now_clock = 32'hFFFF_FFFF - $urandom_range(0, int'(lease_len));  // near wrap
    end else begin
      now_clock = now_clock + $urandom_range(0, step_max);
    end
    item.command      = CMD_ACQUIRE;
    item.fs_id        = 8'($urandom);
    item.key_path     = {$urandom, $urandom};
    item.lease_handle = HANDLE_W'($urandom);
    item.now_time     = now_clock;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_busy[i]) live_slots.push_back(i);
    end
    if (pick < 35) begin
      if ($urandom_range(9) != 0) begin
        item.fs_id    = fs_pool[$urandom_range(3)];
        item.key_path = path_pool[$urandom_range(5)];
      end
    end else if (pick < 55) begin
      item.command = CMD_RENEW;
      if (live_slots.size() > 0 && $urandom_range(4) != 0) begin
        slot = live_slots[$urandom_range(live_slots.size() - 1)];
        item.lease_handle = HANDLE_W'(slot);
        item.fs_id        = slot_owner[slot];
      end
    end else if (pick < 90) begin
      item.command = CMD_RELEASE;
      if (live_slots.size() > 0 && $urandom_range(4) != 0) begin
        slot = live_slots[$urandom_range(live_slots.size() - 1)];
        item.lease_handle = HANDLE_W'(slot);
      end
    end else if (pick < 94) begin
      item.command = CMD_UNUSED;
    end else begin
      item.command = 2'($urandom);
    end
  endtask

  task automatic run_random_phase(input int count, input logic steady,
                                  input logic pause_midway);
    elt_in_t item;
    steady_sender = steady;
    refresh_pools();
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) wait_drained();
      rand_request(item);
      send_item(item);
    end
    steady_sender = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset lifetime of 300: grant, refuse, expiry at the boundary, wrap,
  // renew by the wrong owner, bad handles, release and an unknown command.
  task automatic test_directed_leases();
    send_item(make_req(CMD_ACQUIRE, 8'h00, 64'd0, 4'h0, 32'd0));
    // Expiry wraps past 2^32 and reads as already expired.
    send_item(make_req(CMD_ACQUIRE, 8'hFF, '1, 4'hF, 32'hFFFF_FFFF));
    send_item(make_req(CMD_ACQUIRE, 8'hFF, '1, 4'hF, 32'hFFFF_FFFF));
    // Expiry equal to now still counts as live.
    send_item(make_req(CMD_ACQUIRE, 8'h00, 64'd0, 4'h0, 32'd300));
    send_item(make_req(CMD_RENEW,   8'h00, '1, 4'h0, 32'd300));
    send_item(make_req(CMD_RENEW,   8'h01, 64'd0, 4'h0, 32'd300));  // other owner
    send_item(make_req(CMD_RENEW,   8'hFF, 64'd0, 4'h1, 32'd0));    // unkeyed slot
    send_item(make_req(CMD_RENEW,   8'h00, 64'd0, 4'hF, 32'd0));    // free slot
    // Old lease ran out: match is unkeyed and a fresh slot granted.
    send_item(make_req(CMD_ACQUIRE, 8'h00, 64'd0, 4'h0, 32'd601));
    send_item(make_req(CMD_RELEASE, 8'hA5, '1, 4'h1, 32'hFFFF_FFFF));
    send_item(make_req(CMD_RELEASE, 8'h00, 64'd0, 4'hF, 32'd0));    // already free
    send_item(make_req(CMD_UNUSED,  8'h3C, {$urandom, $urandom}, 4'h7, $urandom));
    send_item(make_req(CMD_RENEW,   8'h00, 64'd0, 4'h0, 32'd601));  // unkeyed now
  endtask

  // Fill every reachable slot, then overflow; an expired match seen while
  // full stays unkeyed even though nothing is granted.
  task automatic test_table_full();
    for (int k = 0; k < REACH; k++) begin
      send_item(make_req(CMD_ACQUIRE, 8'h5A, {$urandom, 32'(k)}, 4'h0, 32'd1000));
    end
    send_item(make_req(CMD_ACQUIRE, 8'h00, 64'd0, 4'h0, 32'd2000));
    send_item(make_req(CMD_ACQUIRE, 8'h00, 64'd0, 4'h0, 32'd2000));
  endtask

  task automatic test_short_lifetime();
    set_lifetime(16'd1);
    run_random_phase(100, 1'b0, 1'b0);
  endtask

  task automatic test_long_lifetime();
    set_lifetime(16'hFFFF);
    run_random_phase(100, 1'b0, 1'b0);
  endtask

  // Lifetime 0 gives expiry equal to now.
  task automatic test_zero_lifetime();
    set_lifetime(16'd0);
    run_random_phase(60, 1'b0, 1'b0);
  endtask

  // Long stretch with the sender never idling.
  task automatic test_steady_random();
    set_lifetime(16'($urandom_range(2, 4000)));
    run_random_phase(150, 1'b1, 1'b0);
  endtask

  // Back to the reset lifetime, with a full drain halfway through.
  task automatic test_drain_pause();
    set_lifetime(LIFETIME_RESET);
    run_random_phase(140, 1'b0, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Result checking: one strobe per result, compared against the oldest
  // owed outcome.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with nothing owed: status %0d handle %0d",
               rsp_o.status, rsp_o.granted_handle);
        mismatch_count++;
      end else begin
        outcome_want = pending_outcomes.pop_front();
        if (rsp_o.status !== outcome_want.status) begin
          $error("status: expected %0d, got %0d", outcome_want.status, rsp_o.status);
          mismatch_count++;
        end
        if (rsp_o.granted_handle !== outcome_want.granted_handle) begin
          $error("granted_handle: expected %0d, got %0d",
                 outcome_want.granted_handle, rsp_o.granted_handle);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long with no accept and no result means a hang.
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    req_i          = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    mismatch_count = 0;
    steady_sender  = 1'b0;
    now_clock      = $urandom;
    lease_len      = LIFETIME_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_busy[i]   = 1'b0;
      slot_keyed[i]  = 1'b0;
      slot_owner[i]  = '0;
      slot_path[i]   = '0;
      slot_expiry[i] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_leases();
    test_table_full();
    test_short_lifetime();
    test_long_lifetime();
    test_zero_lifetime();
    test_steady_random();
    test_drain_pause();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
